FILE: hdl/bhpq_pkg.sv
package bhpq_pkg;

    // Request codes on the input channel.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Status codes on the output channel.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Ranking order.
    localparam logic ORDER_SMALL = 1'b0;
    localparam logic ORDER_LARGE = 1'b1;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER     = 1'd1;

    localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 7'd64;

endpackage

FILE: hdl/bhpq_cell.sv
// One heap level. The cell owns the keys of its level in two banks (even and
// odd positions), so a parent can read both children of a slot in one access.
// A sift token enters from the parent (moving down), the child (moving up)
// or the insert start; unless it ends at once, it waits for a registered pair
// read of the neighbor level; it is handed on or ends with a pulse on o_done.
module bhpq_cell
    import bhpq_pkg::*;
#(
    parameter int KEY_WIDTH  = 32,
    parameter int SLOT_WIDTH = 7,
    parameter int LEVEL      = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_order,
    input  logic [SLOT_WIDTH-1:0]         i_count,
    input  logic [KEY_WIDTH+SLOT_WIDTH:0] i_start,
    input  logic [SLOT_WIDTH:0]           i_fetch,
    input  logic [KEY_WIDTH+SLOT_WIDTH:0] i_dn,
    output logic [KEY_WIDTH+SLOT_WIDTH:0] o_dn,
    input  logic [KEY_WIDTH+SLOT_WIDTH:0] i_up,
    output logic [KEY_WIDTH+SLOT_WIDTH:0] o_up,
    input  logic [SLOT_WIDTH:0]           i_rd_par,
    input  logic [SLOT_WIDTH:0]           i_rd_chd,
    output logic [SLOT_WIDTH:0]           o_rd_dn,
    output logic [SLOT_WIDTH:0]           o_rd_up,
    input  logic [2*KEY_WIDTH-1:0]        i_par_pair,
    input  logic [2*KEY_WIDTH-1:0]        i_chd_pair,
    output logic [2*KEY_WIDTH-1:0]        o_pair,
    output logic [KEY_WIDTH-1:0]          o_fetch,
    output logic                          o_done
);

    typedef struct packed {
        logic                  vld;
        logic [KEY_WIDTH-1:0]  key;
        logic [SLOT_WIDTH-1:0] slot;
    } t_tok;

    typedef struct packed {
        logic                  vld;
        logic [SLOT_WIDTH-1:0] adr;
    } t_rd;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] odd;
        logic [KEY_WIDTH-1:0] even;
    } t_pair;

    typedef enum logic [1:0] {
        C_IDLE,
        C_DN_WAIT,
        C_UP_WAIT
    } t_cstate;

    localparam int ROWW = (LEVEL > 1) ? LEVEL - 1 : 1;
    localparam int ROWS = 1 << ROWW;
    localparam int PLEV = (LEVEL > 0) ? LEVEL - 1 : 0;
    localparam logic [SLOT_WIDTH-1:0] IMASK = SLOT_WIDTH'((1 << LEVEL) - 1);
    localparam logic [SLOT_WIDTH-1:0] PMASK = SLOT_WIDTH'((1 << PLEV) - 1);
    localparam logic [SLOT_WIDTH-1:0] ONE   = SLOT_WIDTH'(1);

    function automatic logic f_higher(input logic order, input logic [KEY_WIDTH-1:0] a,
                                      input logic [KEY_WIDTH-1:0] b);
        return (order == ORDER_LARGE) ? (a > b) : (a < b);
    endfunction

    t_tok  start_tok, dn_in, up_in;
    t_rd   rd_par, rd_chd, fetch_req, rd_dn, rd_up;
    t_pair par_pair, chd_pair;

    t_cstate               r_state, n_state;
    logic [KEY_WIDTH-1:0]  r_key, n_key;
    logic [SLOT_WIDTH-1:0] r_slot, n_slot;
    logic                  r_rex, n_rex;
    logic                  r_pbank, n_pbank;
    t_tok                  r_dn, n_dn;
    t_tok                  r_up, n_up;
    logic                  r_done, n_done;
    logic                  r_fhit, n_fhit;
    logic                  r_fbank, n_fbank;
    t_pair                 r_pair;

    logic [KEY_WIDTH-1:0]  r_mem0 [ROWS];
    logic [KEY_WIDTH-1:0]  r_mem1 [ROWS];

    logic                  w_en;
    logic [SLOT_WIDTH-1:0] w_adr;
    logic [KEY_WIDTH-1:0]  w_data;
    logic [SLOT_WIDTH-1:0] w_idx, w_rowx;
    logic [SLOT_WIDTH-1:0] rd_adr, fetch_idx;

    logic                  start_hit, up_arr;
    logic [KEY_WIDTH-1:0]  up_key;
    logic [SLOT_WIDTH-1:0] up_slot, dn_idx, pidx;
    logic [SLOT_WIDTH:0]   lchild, rchild, cnt_x;
    logic                  lex, rex;
    logic                  l_hi, r_hi, r_over_l, dn_move, pick_r, up_move;
    logic [KEY_WIDTH-1:0]  move_key, pkey;

    assign start_tok = i_start;
    assign dn_in     = i_dn;
    assign up_in     = i_up;
    assign rd_par    = i_rd_par;
    assign rd_chd    = i_rd_chd;
    assign fetch_req = i_fetch;
    assign par_pair  = i_par_pair;
    assign chd_pair  = i_chd_pair;

    assign o_dn    = r_dn;
    assign o_up    = r_up;
    assign o_rd_dn = rd_dn;
    assign o_rd_up = rd_up;
    assign o_pair  = r_pair;
    assign o_done  = r_done;
    assign o_fetch = r_fhit ? (r_fbank ? r_pair.odd : r_pair.even) : '0;

    // Arrival decode and the compares of both directions.
    always_comb begin
        start_hit = start_tok.vld && ((start_tok.slot >> LEVEL) == ONE);
        up_arr    = start_hit || up_in.vld;
        up_key    = start_hit ? start_tok.key : up_in.key;
        up_slot   = start_hit ? start_tok.slot : up_in.slot;
        pidx      = (up_slot >> 1) & PMASK;

        dn_idx = dn_in.slot & IMASK;
        lchild = {dn_in.slot, 1'b0};
        rchild = {dn_in.slot, 1'b1};
        cnt_x  = {1'b0, i_count};
        lex    = (lchild <= cnt_x);
        rex    = (rchild <= cnt_x);

        l_hi     = f_higher(i_order, chd_pair.even, r_key);
        r_hi     = f_higher(i_order, chd_pair.odd, r_key);
        r_over_l = f_higher(i_order, chd_pair.odd, chd_pair.even);
        dn_move  = r_rex ? (l_hi || r_hi) : l_hi;
        pick_r   = r_rex && r_over_l;
        move_key = pick_r ? chd_pair.odd : chd_pair.even;

        pkey    = r_pbank ? par_pair.odd : par_pair.even;
        up_move = f_higher(i_order, r_key, pkey);
    end

    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_slot  = r_slot;
        n_rex   = r_rex;
        n_pbank = r_pbank;
        n_dn    = '0;
        n_up    = '0;
        n_done  = 1'b0;
        rd_dn   = '0;
        rd_up   = '0;
        w_en    = 1'b0;
        w_adr   = r_slot;
        w_data  = r_key;
        n_fhit  = fetch_req.vld && ((fetch_req.adr >> LEVEL) == ONE);
        fetch_idx = fetch_req.adr & IMASK;
        n_fbank = fetch_idx[0];

        unique case (r_state)
            C_IDLE: begin
                if (dn_in.vld) begin
                    if (lex) begin
                        rd_dn.vld = 1'b1;
                        rd_dn.adr = dn_idx;
                        n_key     = dn_in.key;
                        n_slot    = dn_in.slot;
                        n_rex     = rex;
                        n_state   = C_DN_WAIT;
                    end else begin
                        w_en   = 1'b1;
                        w_adr  = dn_in.slot;
                        w_data = dn_in.key;
                        n_done = 1'b1;
                    end
                end else if (up_arr) begin
                    if (LEVEL == 0) begin
                        w_en   = 1'b1;
                        w_adr  = up_slot;
                        w_data = up_key;
                        n_done = 1'b1;
                    end else begin
                        rd_up.vld = 1'b1;
                        rd_up.adr = pidx >> 1;
                        n_pbank   = pidx[0];
                        n_key     = up_key;
                        n_slot    = up_slot;
                        n_state   = C_UP_WAIT;
                    end
                end
            end
            C_DN_WAIT: begin
                w_en    = 1'b1;
                n_state = C_IDLE;
                if (dn_move) begin
                    w_data   = move_key;
                    n_dn.vld = 1'b1;
                    n_dn.key = r_key;
                    n_dn.slot = SLOT_WIDTH'({r_slot, pick_r});
                end else begin
                    n_done = 1'b1;
                end
            end
            C_UP_WAIT: begin
                w_en    = 1'b1;
                n_state = C_IDLE;
                if (up_move) begin
                    w_data    = pkey;
                    n_up.vld  = 1'b1;
                    n_up.key  = r_key;
                    n_up.slot = r_slot >> 1;
                end else begin
                    n_done = 1'b1;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_dn    <= '0;
            r_up    <= '0;
            r_done  <= 1'b0;
            r_fhit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dn    <= n_dn;
            r_up    <= n_up;
            r_done  <= n_done;
            r_fhit  <= n_fhit;
        end
        r_key   <= n_key;
        r_slot  <= n_slot;
        r_rex   <= n_rex;
        r_pbank <= n_pbank;
        r_fbank <= n_fbank;
    end

    // Level storage: one write and one registered pair read per cycle.
    always_comb begin
        w_idx  = w_adr & IMASK;
        w_rowx = w_idx >> 1;
        if (rd_par.vld) begin
            rd_adr = rd_par.adr;
        end else if (rd_chd.vld) begin
            rd_adr = rd_chd.adr;
        end else begin
            rd_adr = fetch_idx >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_idx[0]) begin
                r_mem1[w_rowx[ROWW-1:0]] <= w_data;
            end else begin
                r_mem0[w_rowx[ROWW-1:0]] <= w_data;
            end
        end
        r_pair.even <= r_mem0[rd_adr[ROWW-1:0]];
        r_pair.odd  <= r_mem1[rd_adr[ROWW-1:0]];
    end

endmodule

FILE: hdl/binary_heap_priority_queue_unit.sv
// Bounded priority queue kept as a binary heap of keys. Each transaction on
// the input channel either inserts i_new_key or removes the highest-ranked
// key; each produces exactly one result transaction with a status, the key
// removed, and the top key and entry count after the step. The heap is built
// as a chain of level cells, one per heap level, each owning the keys of its
// level in a small two-bank memory; a sift token travels from cell to cell,
// each level walked taking one registered pair read of the neighbor level
// and then a compare and write. One transaction is worked on at a time; a
// new one is taken while the previous result still waits in the output
// register. Configuration writes are only legal while the queue is idle.
// Changing the order with keys held keeps the stored layout; later steps
// compare under the new order.
module binary_heap_priority_queue_unit
    import bhpq_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [KEY_WIDTH-1:0]               i_new_key,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic [KEY_WIDTH-1:0]               o_removed_key,
    output logic [KEY_WIDTH-1:0]               o_top_key,
    output logic                               o_top_valid,
    output logic [$clog2(CAPACITY+1)-1:0]      o_entry_count,
    input  logic                               i_cfg_we,
    input  logic [CFG_IDX_W-1:0]               i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]              i_cfg_data
);

    // Slots count from 1, so the slot number and the entry count share a width,
    // and the heap has exactly that many levels.
    localparam int SLOT_WIDTH = $clog2(CAPACITY + 1);
    localparam int NLVL       = SLOT_WIDTH;
    localparam int CMPW       = (SLOT_WIDTH > CFG_DATA_W) ? SLOT_WIDTH : CFG_DATA_W;
    localparam logic [SLOT_WIDTH-1:0] ONE   = SLOT_WIDTH'(1);
    localparam logic [CMPW-1:0]       CAP_C = CMPW'(CAPACITY);

    typedef struct packed {
        logic                  vld;
        logic [KEY_WIDTH-1:0]  key;
        logic [SLOT_WIDTH-1:0] slot;
    } t_tok;

    typedef struct packed {
        logic                  vld;
        logic [SLOT_WIDTH-1:0] adr;
    } t_rd;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] odd;
        logic [KEY_WIDTH-1:0] even;
    } t_pair;

    // Idle, wait for the last key, sift in progress, read the new root,
    // capture the root, hand over the result.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_SIFT,
        S_TOPREQ,
        S_TOPWAIT,
        S_OUT
    } t_state;

    t_state                r_state, n_state;
    logic [SLOT_WIDTH-1:0] r_count, n_count;
    logic [CFG_DATA_W-1:0] r_limit;
    logic                  r_order;
    logic [KEY_WIDTH-1:0]  r_top, n_top;
    logic [1:0]            r_status, n_status;
    logic [KEY_WIDTH-1:0]  r_removed, n_removed;
    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_o_status, n_o_status;
    logic [KEY_WIDTH-1:0]  r_o_removed, n_o_removed;
    logic [KEY_WIDTH-1:0]  r_o_top, n_o_top;
    logic                  r_o_top_valid, n_o_top_valid;
    logic [SLOT_WIDTH-1:0] r_o_count, n_o_count;

    t_tok start_tok, root_tok;
    t_rd  fetch_req;

    t_tok  dn_in   [NLVL];
    t_tok  dn_out  [NLVL];
    t_tok  up_in   [NLVL];
    t_tok  up_out  [NLVL];
    t_rd   rdp_in  [NLVL];
    t_rd   rdc_in  [NLVL];
    t_rd   rdd_out [NLVL];
    t_rd   rdu_out [NLVL];
    t_pair pair_out[NLVL];
    t_pair ppair_in[NLVL];
    t_pair cpair_in[NLVL];
    logic [KEY_WIDTH-1:0] fetch_out[NLVL];
    logic                 done_out [NLVL];

    logic                 in_accept, out_take, load_out, any_done, full;
    logic [KEY_WIDTH-1:0] fetch_data;
    logic [CMPW-1:0]      lim_x, eff_lim, cnt_x;

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_removed_key = r_o_removed;
    assign o_top_key     = r_o_top;
    assign o_top_valid   = r_o_top_valid;
    assign o_entry_count = r_o_count;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_take  = r_out_valid && !i_out_stall;

    // The usable limit is the configured one, clipped to what was built.
    always_comb begin
        lim_x   = CMPW'(r_limit);
        eff_lim = (lim_x < CAP_C) ? lim_x : CAP_C;
        cnt_x   = CMPW'(r_count);
        full    = (cnt_x >= eff_lim);
    end

    // Completion pulses and root or last-key reads come back from whichever
    // cell owns the slot; all others drive zero.
    always_comb begin
        any_done   = 1'b0;
        fetch_data = '0;
        for (int l = 0; l < NLVL; l++) begin
            any_done   = any_done | done_out[l];
            fetch_data = fetch_data | fetch_out[l];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = r_top;
        n_status    = r_status;
        n_removed   = r_removed;
        start_tok   = '0;
        root_tok    = '0;
        fetch_req   = '0;
        load_out    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_removed = '0;
                    n_status  = ST_DONE;
                    if (i_req_type == REQ_INSERT) begin
                        if (full) begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            // The new key enters at the next free slot and climbs.
                            start_tok.vld  = 1'b1;
                            start_tok.key  = i_new_key;
                            start_tok.slot = r_count + ONE;
                            n_count        = r_count + ONE;
                            n_state        = S_SIFT;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            // Take the root now and read the last key, which, if keys
                            // remain, will be sifted down from the root.
                            fetch_req.vld = 1'b1;
                            fetch_req.adr = r_count;
                            n_removed     = r_top;
                            n_count       = r_count - ONE;
                            n_state       = S_LAST;
                        end
                    end
                end
            end
            S_LAST: begin
                if (r_count != '0) begin
                    root_tok.vld  = 1'b1;
                    root_tok.key  = fetch_data;
                    root_tok.slot = ONE;
                    n_state       = S_SIFT;
                end else begin
                    n_state = S_TOPREQ;
                end
            end
            S_SIFT: begin
                if (any_done) begin
                    n_state = S_TOPREQ;
                end
            end
            S_TOPREQ: begin
                fetch_req.vld = 1'b1;
                fetch_req.adr = ONE;
                n_state       = S_TOPWAIT;
            end
            S_TOPWAIT: begin
                n_top   = fetch_data;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid   = (r_out_valid && !out_take) || load_out;
        n_o_status    = load_out ? r_status : r_o_status;
        n_o_removed   = load_out ? r_removed : r_o_removed;
        n_o_top       = load_out ? ((r_count != '0) ? r_top : '0) : r_o_top;
        n_o_top_valid = load_out ? (r_count != '0) : r_o_top_valid;
        n_o_count     = load_out ? r_count : r_o_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_order     <= ORDER_SMALL;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CAP_LIMIT: r_limit <= i_cfg_data;
                    CFG_ORDER:     r_order <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        r_top         <= n_top;
        r_status      <= n_status;
        r_removed     <= n_removed;
        r_o_status    <= n_o_status;
        r_o_removed   <= n_o_removed;
        r_o_top       <= n_o_top;
        r_o_top_valid <= n_o_top_valid;
        r_o_count     <= n_o_count;
    end

    // The level chain: pair reads and moving tokens pass only between neighbors.
    for (genvar l = 0; l < NLVL; l++) begin : g_lvl
        if (l == 0) begin : g_first
            assign dn_in[l]    = root_tok;
            assign rdp_in[l]   = '0;
            assign ppair_in[l] = '0;
        end else begin : g_inner_up
            assign dn_in[l]    = dn_out[l-1];
            assign rdp_in[l]   = rdd_out[l-1];
            assign ppair_in[l] = pair_out[l-1];
        end
        if (l == NLVL - 1) begin : g_last
            assign up_in[l]    = '0;
            assign rdc_in[l]   = '0;
            assign cpair_in[l] = '0;
        end else begin : g_inner_dn
            assign up_in[l]    = up_out[l+1];
            assign rdc_in[l]   = rdu_out[l+1];
            assign cpair_in[l] = pair_out[l+1];
        end

        bhpq_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .SLOT_WIDTH(SLOT_WIDTH),
            .LEVEL     (l)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_order   (r_order),
            .i_count   (r_count),
            .i_start   (start_tok),
            .i_fetch   (fetch_req),
            .i_dn      (dn_in[l]),
            .o_dn      (dn_out[l]),
            .i_up      (up_in[l]),
            .o_up      (up_out[l]),
            .i_rd_par  (rdp_in[l]),
            .i_rd_chd  (rdc_in[l]),
            .o_rd_dn   (rdd_out[l]),
            .o_rd_up   (rdu_out[l]),
            .i_par_pair(ppair_in[l]),
            .i_chd_pair(cpair_in[l]),
            .o_pair    (pair_out[l]),
            .o_fetch   (fetch_out[l]),
            .o_done    (done_out[l])
        );
    end

endmodule

FILE: hdl/bhpq_checker.sv
// Port-level checks of the queue.
module bhpq_checker
    import bhpq_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_req_type,
    input logic [KEY_WIDTH-1:0]          i_new_key,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [1:0]                    o_status,
    input logic [KEY_WIDTH-1:0]          o_removed_key,
    input logic [KEY_WIDTH-1:0]          o_top_key,
    input logic                          o_top_valid,
    input logic [$clog2(CAPACITY+1)-1:0] o_entry_count,
    input logic                          i_cfg_we,
    input logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input logic [CFG_DATA_W-1:0]         i_cfg_data
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_top_key) && $stable(o_removed_key) && $stable(o_entry_count))
        else $error("result changed while stalled");

    // The queue works on one transaction at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

    // The top flag agrees with the count.
    a_top_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_top_valid == (o_entry_count != '0)))
        else $error("top flag disagrees with count");

    // A refused remove leaves an empty queue and removes nothing.
    a_empty_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> (o_entry_count == '0)
            && (o_removed_key == '0) && !o_top_valid)
        else $error("empty refusal with keys held");

endmodule

bind binary_heap_priority_queue_unit bhpq_checker #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
) u_bhpq_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bhpq_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int KEY_W       = 32;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    // A sift walks at most six levels.
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } heap_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [KEY_W-1:0]   removed_key;
        logic [KEY_W-1:0]   top_key;
        logic               top_valid;
        logic [COUNT_W-1:0] entry_count;
    } heap_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_req_type = REQ_INSERT;
    logic [KEY_W-1:0]      i_new_key = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_status;
    logic [KEY_W-1:0]      o_removed_key;
    logic [KEY_W-1:0]      o_top_key;
    logic                  o_top_valid;
    logic [COUNT_W-1:0]    o_entry_count;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_CAP_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    binary_heap_priority_queue_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_new_key     (i_new_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_removed_key (o_removed_key),
        .o_top_key     (o_top_key),
        .o_top_valid   (o_top_valid),
        .o_entry_count (o_entry_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Requests waiting to be sent, and the results the heap must produce,
    // oldest first.
    heap_req_t    requests_to_send[$];
    heap_result_t heap_results_due[$];

    // Shadow heap: slots counted from 1, children of slot i at 2i and 2i+1.
    logic [KEY_W-1:0] heap_keys [1:CAPACITY];
    int               shadow_count = 0;
    int               shadow_limit = LIMIT_RESET;
    logic             shadow_order = ORDER_SMALL;

    int               sender_idle_pct = 0;
    int               rx_stall_pct = 0;
    logic             rx_hold_start = 1'b0;
    logic [15:0]      rx_hold_left = '0;
    int               mismatch_count = 0;
    int               cycle_count = 0;

    function automatic logic outranks(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return (shadow_order == ORDER_LARGE) ? (a > b) : (a < b);
    endfunction

    task automatic swap_keys(input int a, input int b);
        logic [KEY_W-1:0] tmp;
        tmp          = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = tmp;
    endtask

    // Applies one accepted transaction to the shadow heap and queues the
    // result the hardware has to return for it.
    task automatic heap_apply(input logic req_type, input logic [KEY_W-1:0] key);
        heap_result_t res;
        int           lim;
        int           pos;
        int           up;
        int           l;
        int           r;
        int           pick;
        res    = '0;
        res.status = ST_DONE;
        lim    = (shadow_limit < CAPACITY) ? shadow_limit : CAPACITY;
        if (req_type == REQ_INSERT) begin
            if (shadow_count >= lim) begin
                res.status = ST_FULL;
            end else begin
                shadow_count++;
                heap_keys[shadow_count] = key;
                pos = shadow_count;
                while (pos > 1) begin
                    up = pos / 2;
                    if (!outranks(heap_keys[pos], heap_keys[up]))
                        break;
                    swap_keys(pos, up);
                    pos = up;
                end
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed_key = heap_keys[1];
                heap_keys[1]    = heap_keys[shadow_count];
                shadow_count--;
                pos = 1;
                // Sift down only when more than one key is left; ties favor
                // the left child and never cause a swap with the parent.
                while (shadow_count > 1 && 2 * pos <= shadow_count) begin
                    l = 2 * pos;
                    r = l + 1;
                    if (r <= shadow_count) begin
                        if (!outranks(heap_keys[l], heap_keys[pos]) &&
                            !outranks(heap_keys[r], heap_keys[pos]))
                            break;
                        pick = outranks(heap_keys[r], heap_keys[l]) ? r : l;
                    end else begin
                        if (!outranks(heap_keys[l], heap_keys[pos]))
                            break;
                        pick = l;
                    end
                    swap_keys(pos, pick);
                    pos = pick;
                end
            end
        end
        res.top_valid   = (shadow_count != 0);
        res.top_key     = (shadow_count != 0) ? heap_keys[1] : '0;
        res.entry_count = shadow_count[COUNT_W-1:0];
        heap_results_due.push_back(res);
    endtask

    task automatic note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch %0d at cycle %0d: %s", mismatch_count, cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (want !== got)
            note_failure($sformatf("%s expected %h actual %h", name, want, got));
    endtask

    // Driver: presents queued requests, holds a stalled transaction steady,
    // and leaves random gaps at the configured rate.
    always @(posedge i_clk) begin : request_driver
        heap_req_t req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                heap_apply(i_req_type, i_new_key);
            if (!i_in_valid || !o_in_stall) begin
                if (requests_to_send.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    req = requests_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_req_type <= req.req_type;
                    i_new_key  <= req.key;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only reads it.
    always @(posedge i_clk) begin
        if (rx_hold_start)
            rx_hold_left <= LONG_HOLD;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1'b1;
    end

    // Monitor: every result transaction is matched against the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin : result_monitor
        heap_result_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (heap_results_due.size() == 0) begin
                    note_failure("result transaction with no request outstanding");
                end else begin
                    want = heap_results_due.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("removed_key", want.removed_key, o_removed_key);
                    check_field("top_key", want.top_key, o_top_key);
                    check_field("top_valid", want.top_valid, o_top_valid);
                    check_field("entry_count", want.entry_count, o_entry_count);
                end
            end
            i_out_stall <= (rx_hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic add_req(input logic req_type, input logic [KEY_W-1:0] key);
        heap_req_t req;
        req.req_type = req_type;
        req.key      = key;
        requests_to_send.push_back(req);
    endtask

    // Returns once every queued request was sent and answered, plus a margin
    // that covers the longest sift.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (requests_to_send.size() != 0 || i_in_valid || heap_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_CAP_LIMIT)
            shadow_limit = data;
        else
            shadow_order = data[0];
    endtask

    task automatic start_phase(input int limit, input logic order, input int idle_pct,
                               input int stall_pct);
        wait_drained();
        write_reg(CFG_CAP_LIMIT, limit[CFG_DATA_W-1:0]);
        write_reg(CFG_ORDER, {{(CFG_DATA_W-1){1'b0}}, order});
        @(negedge i_clk);
        sender_idle_pct = idle_pct;
        rx_stall_pct    = stall_pct;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom_range(7);          // narrow range, plenty of ties
            1: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Bursts that mostly fill or mostly drain the heap, so the random part
    // reaches full and empty as well as deep sifts in between.
    task automatic queue_random_requests(input int n);
        int   burst_left;
        logic fill_burst;
        logic req_type;
        burst_left = 0;
        fill_burst = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                fill_burst = $urandom_range(1);
            end
            if ($urandom_range(99) < 85)
                req_type = fill_burst ? REQ_INSERT : REQ_REMOVE;
            else
                req_type = fill_burst ? REQ_REMOVE : REQ_INSERT;
            add_req(req_type, pick_key());
            burst_left--;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: empty remove, extremes, equal keys, then drain.
        add_req(REQ_REMOVE, 32'h1234_5678);
        add_req(REQ_INSERT, 32'hFFFF_FFFF);
        add_req(REQ_INSERT, 32'h0000_0000);
        add_req(REQ_INSERT, 32'h0000_0000);
        add_req(REQ_INSERT, 32'h0000_0005);
        add_req(REQ_INSERT, 32'h8000_0000);
        add_req(REQ_INSERT, 32'h0000_0005);
        repeat (6) add_req(REQ_REMOVE, 32'hFFFF_FFFF);
        add_req(REQ_REMOVE, 32'h0000_0000);

        // Tiny limit with larger-first order: the third insert is refused.
        start_phase(2, ORDER_LARGE, 0, 0);
        add_req(REQ_INSERT, 32'd7);
        add_req(REQ_INSERT, 32'd9);
        add_req(REQ_INSERT, 32'd3);
        repeat (3) add_req(REQ_REMOVE, 32'd0);

        // A limit of zero refuses every insert.
        start_phase(0, ORDER_SMALL, 0, 0);
        add_req(REQ_INSERT, 32'd1);
        add_req(REQ_REMOVE, 32'd1);

        start_phase(64, ORDER_SMALL, 0, 0);
        queue_random_requests(150);

        // The order flips while keys are still held; the layout stays as is.
        start_phase(64, ORDER_LARGE, 45, 0);
        queue_random_requests(150);

        // Limit lowered below the count: inserts refused until it drains.
        start_phase(3, ORDER_LARGE, 0, 45);
        queue_random_requests(100);

        // Limit above the build size; the receiver holds off for a long
        // stretch first so the block backs up and stalls its input.
        start_phase(127, ORDER_SMALL, 19, 19);
        @(posedge i_clk);
        rx_hold_start <= 1'b1;
        @(posedge i_clk);
        rx_hold_start <= 1'b0;
        queue_random_requests(150);

        start_phase(1, ORDER_LARGE, 0, 0);
        queue_random_requests(80);

        // The sender stops halfway until every result is back.
        start_phase(64, ORDER_SMALL, 19, 19);
        queue_random_requests(75);
        wait_drained();
        queue_random_requests(75);

        start_phase(100, ORDER_LARGE, 45, 0);
        queue_random_requests(120);

        start_phase(40, ORDER_SMALL, 0, 45);
        queue_random_requests(100);

        wait_drained();
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
